/* design/pist_pkg.sv */
// Shared widths, types and command codes for the point-in-shape hit test.
package pist_pkg;

  localparam int COORD_BITS = 12;
  localparam int THICK_BITS = 10;

  // Signed coordinate difference and its products.
  localparam int DW   = COORD_BITS + 1;
  localparam int PW   = 2 * DW;
  localparam int SQ_W = 2 * COORD_BITS;

  // Circle radius plus or minus thickness.
  localparam int RPW   = ((COORD_BITS > THICK_BITS) ? COORD_BITS : THICK_BITS) + 1;
  localparam int CIR_W = 2 * RPW;

  // Compare widths inside a line lane.
  localparam int NEAR_W = ((2 * COORD_BITS + 3) > (2 * THICK_BITS)) ?
                          (2 * COORD_BITS + 3) : (2 * THICK_BITS);
  localparam int HN_W   = ((COORD_BITS + 1) > THICK_BITS) ? (COORD_BITS + 1) : THICK_BITS;
  localparam int LIN_W  = ((4 * COORD_BITS + 4) > (2 * THICK_BITS + 2 * COORD_BITS + 1)) ?
                          (4 * COORD_BITS + 4) : (2 * THICK_BITS + 2 * COORD_BITS + 1);
  localparam int TRI_W  = PW + 2;

  localparam int LANES    = 4;
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = 2;
  localparam int FQ_CW    = FQ_AW + 1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [THICK_BITS-1:0] thick_t;
  typedef logic signed [DW-1:0]  sd_t;

  typedef enum logic [1:0] {
    CMD_LINE   = 2'd0,
    CMD_CIRCLE = 2'd1,
    CMD_RECT   = 2'd2,
    CMD_TRI    = 2'd3
  } cmd_t;

  // One segment tested as a thick line: point minus ends, and line normal.
  typedef struct packed {
    logic en;
    sd_t  d0x;
    sd_t  d0y;
    sd_t  d1x;
    sd_t  d1y;
    sd_t  a;
    sd_t  b;
  } seg_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    cmd_t                  cmd;
    logic                  filled;
    thick_t                thick;
    seg_t [LANES-1:0]      seg;
    sd_t                   pax;
    sd_t                   pay;
    sd_t                   pbx;
    sd_t                   pby;
    sd_t                   pcx;
    sd_t                   pcy;
    sd_t                   wx;
    sd_t                   wy;
    sd_t                   e2x;
    sd_t                   e2y;
    logic [RPW-1:0]        rad;
    logic [RPW-1:0]        rpt;
    logic signed [RPW:0]   rmt;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fq_stat_t;

endpackage

/* design/pist_front.sv */
// Front end: accepts a shape transaction, classifies it into segments and operands.
module pist_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic              in_filled,
  input  pist_pkg::coord_t  in_ax,
  input  pist_pkg::coord_t  in_ay,
  input  pist_pkg::coord_t  in_bx,
  input  pist_pkg::coord_t  in_by,
  input  pist_pkg::coord_t  in_cx,
  input  pist_pkg::coord_t  in_cy,
  input  pist_pkg::coord_t  in_radius,
  input  pist_pkg::thick_t  in_thickness,
  input  pist_pkg::coord_t  in_query_x,
  input  pist_pkg::coord_t  in_query_y,
  input  logic              fq_ready,
  output logic              fr_valid,
  output pist_pkg::item_t   fr_item
);
  import pist_pkg::*;

  logic   fr_valid_r;
  item_t  fr_item_r;
  item_t  item_nxt;
  cmd_t   cmd;
  logic   outline;
  coord_t lx, ly, hx, hy;

  function automatic sd_t dif(coord_t u, coord_t v);
    return $signed({1'b0, u}) - $signed({1'b0, v});
  endfunction

  function automatic seg_t mk_seg(logic en, coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                  coord_t px, coord_t py);
    seg_t s;
    s.en  = en;
    s.d0x = dif(px, x0);
    s.d0y = dif(py, y0);
    s.d1x = dif(px, x1);
    s.d1y = dif(py, y1);
    s.a   = dif(y1, y0);
    s.b   = dif(x0, x1);
    return s;
  endfunction

  // Classify the shape into up to four line segments plus area operands.
  always_comb begin
    cmd     = cmd_t'(in_command);
    outline = !in_filled;
    lx = (in_ax < in_bx) ? in_ax : in_bx;
    hx = (in_ax < in_bx) ? in_bx : in_ax;
    ly = (in_ay < in_by) ? in_ay : in_by;
    hy = (in_ay < in_by) ? in_by : in_ay;

    item_nxt.cmd    = cmd;
    item_nxt.filled = in_filled;
    item_nxt.thick  = in_thickness;
    for (int i = 0; i < LANES; i++) begin
      item_nxt.seg[i] = mk_seg(1'b0, in_ax, in_ay, in_bx, in_by, in_query_x, in_query_y);
    end
    case (cmd)
      CMD_LINE: begin
        item_nxt.seg[0] = mk_seg(1'b1, in_ax, in_ay, in_bx, in_by, in_query_x, in_query_y);
      end
      CMD_RECT: begin
        item_nxt.seg[0] = mk_seg(outline, lx, ly, hx, ly, in_query_x, in_query_y);
        item_nxt.seg[1] = mk_seg(outline, hx, ly, hx, hy, in_query_x, in_query_y);
        item_nxt.seg[2] = mk_seg(outline, hx, hy, lx, hy, in_query_x, in_query_y);
        item_nxt.seg[3] = mk_seg(outline, lx, hy, lx, ly, in_query_x, in_query_y);
      end
      CMD_TRI: begin
        item_nxt.seg[0] = mk_seg(outline, in_ax, in_ay, in_bx, in_by, in_query_x, in_query_y);
        item_nxt.seg[1] = mk_seg(outline, in_bx, in_by, in_cx, in_cy, in_query_x, in_query_y);
        item_nxt.seg[2] = mk_seg(outline, in_cx, in_cy, in_ax, in_ay, in_query_x, in_query_y);
      end
      default: begin
      end
    endcase

    item_nxt.pax = dif(in_query_x, in_ax);
    item_nxt.pay = dif(in_query_y, in_ay);
    item_nxt.pbx = dif(in_query_x, in_bx);
    item_nxt.pby = dif(in_query_y, in_by);
    item_nxt.pcx = dif(in_query_x, in_cx);
    item_nxt.pcy = dif(in_query_y, in_cy);
    item_nxt.wx  = dif(in_bx, in_ax);
    item_nxt.wy  = dif(in_by, in_ay);
    item_nxt.e2x = dif(in_cx, in_ax);
    item_nxt.e2y = dif(in_cy, in_ay);
    item_nxt.rad = RPW'(in_radius);
    item_nxt.rpt = RPW'(in_radius) + RPW'(in_thickness);
    item_nxt.rmt = $signed({1'b0, RPW'(in_radius)}) - $signed({1'b0, RPW'(in_thickness)});
  end

  // Front register: refills in the same cycle that it hands its item to the queue.
  assign in_ready = !fr_valid_r || fq_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      fr_valid_r <= 1'b1;
    end else if (fq_ready) begin
      fr_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      fr_item_r <= item_nxt;
    end
  end

  assign fr_valid = fr_valid_r;
  assign fr_item  = fr_item_r;

endmodule

/* design/pist_queue.sv */
// Short queue of classified items between the front and the back.
module pist_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  pist_pkg::item_t    push_item,
  input  logic               pop,
  output pist_pkg::item_t    head,
  output pist_pkg::fq_stat_t stat
);
  import pist_pkg::*;

  item_t            slot_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_r, rd_r;
  logic [FQ_CW-1:0] cnt_r, cnt_nxt;

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FQ_CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FQ_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_r <= wr_r + FQ_AW'(1);
      end
      if (pop) begin
        rd_r <= rd_r + FQ_AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_item;
    end
  end

  assign head       = slot_r[rd_r];
  assign stat.full  = (cnt_r == FQ_CW'(FQ_DEPTH));
  assign stat.empty = (cnt_r == '0);

endmodule

/* design/pist_line_lane.sv */
// One thick-line test lane: three pipeline stages of squares and products.
module pist_line_lane (
  input  logic             clk,
  input  logic             en,
  input  pist_pkg::seg_t   seg_in,
  input  pist_pkg::thick_t thick,
  output logic             hit
);
  import pist_pkg::*;

  // Stage one: squares, normal products and range flags.
  logic                      en1_r, inx1_r, iny1_r, hz1_r, vt1_r, hn1_r, vn1_r;
  logic [SQ_W-1:0]           sq0x_r, sq0y_r, sq1x_r, sq1y_r, aa_r, bb_r;
  logic signed [PW-1:0]      pa_r, pb_r;
  logic [2*THICK_BITS-1:0]   tt1_r;
  // Stage two: sums and the endpoint-disc flag.
  logic                      en2_r, inx2_r, iny2_r, hz2_r, vt2_r, hn2_r, vn2_r, near2_r;
  logic signed [PW:0]        num_r;
  logic [SQ_W:0]             s_r;
  logic [2*THICK_BITS-1:0]   tt2_r;
  // Stage three: squared distance against the scaled thickness.
  logic                      en3_r, inx3_r, iny3_r, hz3_r, vt3_r, hn3_r, vn3_r, near3_r;
  logic [4*COORD_BITS+1:0]   nn_r;
  logic [2*THICK_BITS+SQ_W:0] rr_r;

  logic signed [PW-1:0]      q0x, q0y, q1x, q1y, qa, qb;
  logic [SQ_W:0]             n0, n1;
  logic signed [PW:0]        mag;
  logic [2*COORD_BITS:0]     nabs;

  function automatic coord_t absc(sd_t v);
    sd_t n;
    n = v[DW-1] ? -v : v;
    return n[COORD_BITS-1:0];
  endfunction

  always_comb begin
    q0x = seg_in.d0x * seg_in.d0x;
    q0y = seg_in.d0y * seg_in.d0y;
    q1x = seg_in.d1x * seg_in.d1x;
    q1y = seg_in.d1y * seg_in.d1y;
    qa  = seg_in.a * seg_in.a;
    qb  = seg_in.b * seg_in.b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      en1_r  <= seg_in.en;
      sq0x_r <= q0x[SQ_W-1:0];
      sq0y_r <= q0y[SQ_W-1:0];
      sq1x_r <= q1x[SQ_W-1:0];
      sq1y_r <= q1y[SQ_W-1:0];
      aa_r   <= qa[SQ_W-1:0];
      bb_r   <= qb[SQ_W-1:0];
      pa_r   <= seg_in.a * seg_in.d0x;
      pb_r   <= seg_in.b * seg_in.d0y;
      tt1_r  <= thick * thick;
      inx1_r <= !((seg_in.d0x > 0 && seg_in.d1x > 0) || (seg_in.d0x < 0 && seg_in.d1x < 0));
      iny1_r <= !((seg_in.d0y > 0 && seg_in.d1y > 0) || (seg_in.d0y < 0 && seg_in.d1y < 0));
      hz1_r  <= (seg_in.a == '0);
      vt1_r  <= (seg_in.b == '0);
      hn1_r  <= HN_W'({absc(seg_in.d0y), 1'b0}) <= HN_W'(thick);
      vn1_r  <= HN_W'({absc(seg_in.d0x), 1'b0}) <= HN_W'(thick);
    end
  end

  // Endpoint discs: 4*|PA|^2 <= t^2.
  assign n0 = {1'b0, sq0x_r} + {1'b0, sq0y_r};
  assign n1 = {1'b0, sq1x_r} + {1'b0, sq1y_r};

  always_ff @(posedge clk) begin
    if (en) begin
      en2_r   <= en1_r;
      inx2_r  <= inx1_r;
      iny2_r  <= iny1_r;
      hz2_r   <= hz1_r;
      vt2_r   <= vt1_r;
      hn2_r   <= hn1_r;
      vn2_r   <= vn1_r;
      near2_r <= (NEAR_W'({n0, 2'b00}) <= NEAR_W'(tt1_r)) ||
                 (NEAR_W'({n1, 2'b00}) <= NEAR_W'(tt1_r));
      num_r   <= pa_r + pb_r;
      s_r     <= {1'b0, aa_r} + {1'b0, bb_r};
      tt2_r   <= tt1_r;
    end
  end

  // Inside the bounding box the line distance numerator fits 2*COORD_BITS+1 bits.
  assign mag  = num_r[PW] ? -num_r : num_r;
  assign nabs = mag[2*COORD_BITS:0];

  always_ff @(posedge clk) begin
    if (en) begin
      en3_r   <= en2_r;
      inx3_r  <= inx2_r;
      iny3_r  <= iny2_r;
      hz3_r   <= hz2_r;
      vt3_r   <= vt2_r;
      hn3_r   <= hn2_r;
      vn3_r   <= vn2_r;
      near3_r <= near2_r;
      nn_r    <= nabs * nabs;
      rr_r    <= tt2_r * s_r;
    end
  end

  // Endpoint discs first; axis-aligned lines: band test; others: squared distance.
  always_comb begin
    if (near3_r) begin
      hit = en3_r;
    end else if (hz3_r) begin
      hit = en3_r && inx3_r && hn3_r;
    end else if (vt3_r) begin
      hit = en3_r && iny3_r && vn3_r;
    end else begin
      hit = en3_r && inx3_r && iny3_r && (LIN_W'({nn_r, 2'b00}) <= LIN_W'(rr_r));
    end
  end

endmodule

/* design/pist_back.sv */
// Back end: area tests and line lanes in a three-stage pipeline with an output register.
module pist_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pist_pkg::item_t    head,
  input  pist_pkg::fq_stat_t stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit
);
  import pist_pkg::*;

  logic             adv;
  logic [LANES-1:0] lane_hit;

  logic                 v1_r, fill1_r;
  cmd_t                 cmd1_r;
  logic [SQ_W-1:0]      csx_r, csy_r, wxx_r, wyy_r;
  logic [CIR_W-1:0]     r2_r, rp2_r, rm2_r;
  logic                 rmneg_r;
  logic signed [PW-1:0] dab_r, dad_r;
  logic signed [PW-1:0] p1_r, p2_r, p3_r, p4_r, p5_r, p6_r, p7_r, p8_r;

  logic                 v2_r, fill2_r, chit2_r, rhit2_r;
  cmd_t                 cmd2_r;
  logic [PW-1:0]        t1_r, t2_r, t3_r, td2_r;

  logic                 v3_r, fill3_r, chit3_r, rhit3_r;
  cmd_t                 cmd3_r;
  logic [TRI_W-1:0]     tsum_r;
  logic [PW-1:0]        td3_r;

  logic                 out_valid_r, out_hit_r, hit_nxt;

  logic signed [PW-1:0]      qx, qy, wq, hq;
  logic signed [2*RPW+1:0]   rmsq;
  logic [SQ_W:0]             dsq;
  logic                      chit;

  function automatic logic [PW-1:0] absd(logic signed [PW:0] v);
    logic signed [PW:0] n;
    n = v[PW] ? -v : v;
    return n[PW-1:0];
  endfunction

  // The whole pipeline advances whenever the output register can take a result.
  assign adv = !out_valid_r || out_ready;
  assign pop = adv && !stat.empty;

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    pist_line_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .seg_in (head.seg[i]),
      .thick  (head.thick),
      .hit    (lane_hit[i])
    );
  end

  // Stage one: products for circle, rectangle and triangle tests.
  always_comb begin
    qx   = head.pax * head.pax;
    qy   = head.pay * head.pay;
    wq   = head.wx * head.wx;
    hq   = head.wy * head.wy;
    rmsq = head.rmt * head.rmt;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd1_r  <= head.cmd;
      fill1_r <= head.filled;
      csx_r   <= qx[SQ_W-1:0];
      csy_r   <= qy[SQ_W-1:0];
      wxx_r   <= wq[SQ_W-1:0];
      wyy_r   <= hq[SQ_W-1:0];
      r2_r    <= head.rad * head.rad;
      rp2_r   <= head.rpt * head.rpt;
      rm2_r   <= rmsq[CIR_W-1:0];
      rmneg_r <= head.rmt[RPW];
      dab_r   <= head.pax * head.wx;
      dad_r   <= head.pay * head.wy;
      p1_r    <= head.pax * head.pby;
      p2_r    <= head.pay * head.pbx;
      p3_r    <= head.pbx * head.pcy;
      p4_r    <= head.pby * head.pcx;
      p5_r    <= head.pcx * head.pay;
      p6_r    <= head.pcy * head.pax;
      p7_r    <= head.wx * head.e2y;
      p8_r    <= head.wy * head.e2x;
    end
  end

  // Stage two: circle and rectangle compares, triangle cross products.
  assign dsq = {1'b0, csx_r} + {1'b0, csy_r};

  always_comb begin
    if (fill1_r) begin
      chit = CIR_W'(dsq) <= r2_r;
    end else begin
      chit = (CIR_W'(dsq) <= rp2_r) && !(!rmneg_r && (CIR_W'(dsq) <= rm2_r));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd2_r  <= cmd1_r;
      fill2_r <= fill1_r;
      chit2_r <= chit;
      rhit2_r <= (dab_r > 0) && (dab_r < $signed({1'b0, wxx_r})) &&
                 (dad_r > 0) && (dad_r < $signed({1'b0, wyy_r}));
      t1_r    <= absd((PW + 1)'(p1_r) - (PW + 1)'(p2_r));
      t2_r    <= absd((PW + 1)'(p3_r) - (PW + 1)'(p4_r));
      t3_r    <= absd((PW + 1)'(p5_r) - (PW + 1)'(p6_r));
      td2_r   <= absd((PW + 1)'(p7_r) - (PW + 1)'(p8_r));
    end
  end

  // Stage three: sum of sub-areas.
  always_ff @(posedge clk) begin
    if (adv) begin
      cmd3_r  <= cmd2_r;
      fill3_r <= fill2_r;
      chit3_r <= chit2_r;
      rhit3_r <= rhit2_r;
      tsum_r  <= {2'b00, t1_r} + {2'b00, t2_r} + {2'b00, t3_r};
      td3_r   <= td2_r;
    end
  end

  // Pick the answer for the shape kind.
  always_comb begin
    case (cmd3_r)
      CMD_LINE:   hit_nxt = |lane_hit;
      CMD_CIRCLE: hit_nxt = chit3_r;
      CMD_RECT:   hit_nxt = fill3_r ? rhit3_r : |lane_hit;
      CMD_TRI:    hit_nxt = fill3_r ? (tsum_r == {2'b00, td3_r}) : |lane_hit;
      default:    hit_nxt = 1'b0;
    endcase
  end

  // Stage valid bits and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= !stat.empty;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= hit_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

/* design/point_in_shape_hit_test.sv */
// Point-in-shape hit test: one line, circle, rectangle or triangle query per transaction.
// A result passes the front register, the queue, the back-end stages and the output register.
// Throughput: one transaction per cycle unless stalled; multipliers are fully pipelined.
// A four-entry queue lets the front keep accepting while the result side stalls.
// Reset (synchronous, active low) empties the front register, queue and pipeline.
module point_in_shape_hit_test (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_command,
  input  logic              in_filled,
  input  pist_pkg::coord_t  in_ax,
  input  pist_pkg::coord_t  in_ay,
  input  pist_pkg::coord_t  in_bx,
  input  pist_pkg::coord_t  in_by,
  input  pist_pkg::coord_t  in_cx,
  input  pist_pkg::coord_t  in_cy,
  input  pist_pkg::coord_t  in_radius,
  input  pist_pkg::thick_t  in_thickness,
  input  pist_pkg::coord_t  in_query_x,
  input  pist_pkg::coord_t  in_query_y,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_hit
);
  import pist_pkg::*;

  logic     fr_valid, fq_push, fq_pop;
  item_t    fr_item, fq_head;
  fq_stat_t fq_stat;

  pist_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_filled    (in_filled),
    .in_ax        (in_ax),
    .in_ay        (in_ay),
    .in_bx        (in_bx),
    .in_by        (in_by),
    .in_cx        (in_cx),
    .in_cy        (in_cy),
    .in_radius    (in_radius),
    .in_thickness (in_thickness),
    .in_query_x   (in_query_x),
    .in_query_y   (in_query_y),
    .fq_ready     (!fq_stat.full),
    .fr_valid     (fr_valid),
    .fr_item      (fr_item)
  );

  assign fq_push = fr_valid && !fq_stat.full;

  pist_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_item (fr_item),
    .pop       (fq_pop),
    .head      (fq_head),
    .stat      (fq_stat)
  );

  pist_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (fq_head),
    .stat      (fq_stat),
    .pop       (fq_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_hit   (out_hit)
  );

`ifndef NO_ASSERTIONS
  a_queue_state: assert property (@(posedge clk) disable iff (!rst_n)
    !(fq_stat.full && fq_stat.empty))
    else $error("queue reports full and empty at once");

  a_front_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> fr_valid)
    else $error("accepted transaction not held in front register");

  a_stall_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !fq_pop)
    else $error("queue popped while result side is stalled");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> !fq_stat.empty)
    else $error("queue popped while empty");
`endif

endmodule
